// ----- sv/stp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the stepper position controller.
// Used by stp_cfg_regs, stp_core and the top level; depends on nothing.
package stp_pkg;

  // Default position width; positions are kept signed in this many bits.
  localparam int unsigned POS_BITS_DEF = 16;

  // Widths fixed by the stream and register layouts.
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned PERIOD_W  = 26;
  localparam int unsigned WAKE_W    = 16;
  localparam int unsigned THRESH_W  = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = PERIOD_W;

  // Register reset values.
  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = PERIOD_W'(5859);
  localparam logic [WAKE_W-1:0]   WAKE_DELAY_RST  = WAKE_W'(2000);
  localparam logic [THRESH_W-1:0] THRESHOLD_RST   = THRESH_W'(36);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_PERIOD      = 2'd0,
    CFG_WAKE_DELAY       = 2'd1,
    CFG_CLOSED_THRESHOLD = 2'd2,
    CFG_UNUSED           = 2'd3
  } cfg_idx_e;

  // Input item kinds.
  typedef enum logic [1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_SET_TARGET = 2'd1,
    FUNC_RESTORE    = 2'd2,
    FUNC_RESET      = 2'd3
  } func_e;

  // Blind position classes.
  typedef enum logic [1:0] {
    CLASS_OPEN    = 2'd0,
    CLASS_OPENING = 2'd1,
    CLASS_CLOSED  = 2'd2,
    CLASS_CLOSING = 2'd3
  } motion_class_e;

  // Configuration as seen by the core.
  typedef struct packed {
    logic [PERIOD_W-1:0] step_period;
    logic [WAKE_W-1:0]   wake_delay;
    logic [THRESH_W-1:0] closed_threshold;
  } stp_cfg_t;

  // One result item.
  typedef struct packed {
    logic                step_pulse;
    logic                dir_level;
    logic                driver_awake;
    logic [VALUE_W-1:0]  current_position;
    logic [VALUE_W-1:0]  target_position;
    motion_class_e       motion_class;
    logic                restored_flag;
  } stp_result_t;

  // Packed result width and the padded stream width.
  localparam int unsigned RESULT_W = 3 + 2 * VALUE_W + 2 + 1;
  localparam int unsigned M_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ----- sv/stepper_position_stepper.sv -----
`timescale 1ns / 1ps
// Stepper step/direction position controller, top level.
// An input transaction is held in the input register, processed by the update
// logic and captured in the result register, from which the result is offered.
// Throughput: one item per cycle while the result stream takes results; a held
// result with m_axis_tready low stalls processing of the held input item.
// Reset (rst_ni, asynchronous, active low) clears positions, motion state and
// the restored flag, empties both registers and restores the register defaults.
module stepper_position_stepper #(
  parameter int unsigned POS_BITS = stp_pkg::POS_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [stp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [stp_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [stp_pkg::VALUE_W-1:0]      s_axis_tdata,  // [15:0] position_value
  input  logic [1:0]                       s_axis_tuser,  // [1:0] func
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] step_pulse, [1] dir_level, [2] driver_awake, [18:3] current_position,
  // [34:19] target_position, [36:35] motion_class, [37] restored_flag,
  // [39:38] zero
  output logic [stp_pkg::M_DATA_W-1:0]     m_axis_tdata
);
  import stp_pkg::*;

  stp_cfg_t    cfg;
  stp_result_t result;

  logic               in_valid_q, in_valid_d;
  func_e              in_func_q;
  logic [VALUE_W-1:0] in_value_q;
  logic               out_valid_q, out_valid_d;
  stp_result_t        out_q;
  logic               in_take;
  logic               advance;

  stp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The held item is processed whenever the result register is free or drains.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  stp_core #(
    .POS_BITS (POS_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .func_i   (in_func_q),
    .value_i  (in_value_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Input register occupancy.
  always_comb begin
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  // Result register occupancy.
  always_comb begin
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_func_q  <= func_e'(s_axis_tuser);
      in_value_q <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  // Pack the result transaction, first field lowest.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_DATA_W'({out_q.restored_flag,
                                    out_q.motion_class,
                                    out_q.target_position,
                                    out_q.current_position,
                                    out_q.driver_awake,
                                    out_q.dir_level,
                                    out_q.step_pulse});

endmodule

// ----- sv/stp_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register bank of the stepper position controller.
// Depends on stp_pkg for the register indexes, widths and reset values.
module stp_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [stp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [stp_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  output stp_pkg::stp_cfg_t                cfg_o
);
  import stp_pkg::*;

  logic [PERIOD_W-1:0] step_period_q;
  logic [WAKE_W-1:0]   wake_delay_q;
  logic [THRESH_W-1:0] threshold_q;
  logic                wr_en;

  // Writes are always taken; an index past the list is dropped.
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_period_q <= STEP_PERIOD_RST;
      wake_delay_q  <= WAKE_DELAY_RST;
      threshold_q   <= THRESHOLD_RST;
    end else if (wr_en) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STEP_PERIOD:      step_period_q <= cfg_data_i[PERIOD_W-1:0];
        CFG_WAKE_DELAY:       wake_delay_q  <= cfg_data_i[WAKE_W-1:0];
        CFG_CLOSED_THRESHOLD: threshold_q   <= cfg_data_i[THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o.step_period      = step_period_q;
  assign cfg_o.wake_delay       = wake_delay_q;
  assign cfg_o.closed_threshold = threshold_q;

endmodule

// ----- sv/stp_core.sv -----
`timescale 1ns / 1ps
// Motion state and single-pass update logic of the stepper position controller.
// Depends on stp_pkg for item kinds, classes, the config and the result structs.
module stp_core #(
  parameter int unsigned POS_BITS = stp_pkg::POS_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  stp_pkg::func_e                    func_i,
  input  logic signed [stp_pkg::VALUE_W-1:0] value_i,
  input  stp_pkg::stp_cfg_t                 cfg_i,
  output stp_pkg::stp_result_t              result_o
);
  import stp_pkg::*;

  localparam int unsigned MAG_W = (POS_BITS > THRESH_W) ? POS_BITS : THRESH_W;

  logic signed [POS_BITS-1:0] cur_q, cur_d;
  logic signed [POS_BITS-1:0] tgt_q, tgt_d;
  logic                       awake_q, awake_d;
  logic                       dir_q, dir_d;
  logic [PERIOD_W-1:0]        cd_q, cd_d;
  logic                       restored_q, restored_d;

  logic signed [POS_BITS-1:0] val;
  logic [PERIOD_W-1:0]        cd_start;
  logic [PERIOD_W-1:0]        cd_dec;
  logic                       step;
  logic [POS_BITS-1:0]        cur_mag;
  logic [POS_BITS-1:0]        tgt_mag;
  motion_class_e              cls;

  // The incoming value is sign-extended or cut to the position width.
  assign val = POS_BITS'(value_i);

  // Countdown source and its decrement, used on a moving tick.
  assign cd_start = awake_q ? cd_q : PERIOD_W'(cfg_i.wake_delay);
  assign cd_dec   = (cd_start != '0) ? (cd_start - PERIOD_W'(1)) : cd_start;

  // Next state for one item.
  always_comb begin
    cur_d      = cur_q;
    tgt_d      = tgt_q;
    awake_d    = awake_q;
    dir_d      = dir_q;
    cd_d       = cd_q;
    restored_d = restored_q;
    step       = 1'b0;
    case (func_i)
      FUNC_SET_TARGET: begin
        tgt_d = val;
      end
      FUNC_RESTORE: begin
        cur_d      = val;
        tgt_d      = val;
        restored_d = 1'b1;
      end
      FUNC_RESET: begin
        cur_d      = '0;
        tgt_d      = '0;
        restored_d = 1'b1;
      end
      default: begin
        if (tgt_q != cur_q) begin
          dir_d   = (tgt_q < cur_q);
          awake_d = 1'b1;
          cd_d    = cd_dec;
          if (cd_dec == '0) begin
            step  = 1'b1;
            cur_d = dir_d ? (cur_q - POS_BITS'(1)) : (cur_q + POS_BITS'(1));
            cd_d  = cfg_i.step_period;
            if (cur_d == tgt_q) begin
              awake_d = 1'b0;
            end
          end
        end
      end
    endcase
  end

  // Magnitudes of the updated positions; the most negative value maps to its
  // unsigned magnitude.
  assign cur_mag = cur_d[POS_BITS-1] ? (~cur_d + POS_BITS'(1)) : cur_d;
  assign tgt_mag = tgt_d[POS_BITS-1] ? (~tgt_d + POS_BITS'(1)) : tgt_d;

  // Position class after this item.
  always_comb begin
    if (tgt_d != cur_d) begin
      cls = (tgt_mag > cur_mag) ? CLASS_CLOSING : CLASS_OPENING;
    end else begin
      cls = (MAG_W'(cur_mag) > MAG_W'(cfg_i.closed_threshold)) ? CLASS_CLOSED : CLASS_OPEN;
    end
  end

  // Result fields; positions show their low sixteen bits, sign-extended when
  // the position width is narrower.
  always_comb begin
    result_o.step_pulse       = step;
    result_o.dir_level        = dir_d;
    result_o.driver_awake     = awake_d;
    result_o.current_position = VALUE_W'(cur_d);
    result_o.target_position  = VALUE_W'(tgt_d);
    result_o.motion_class     = cls;
    result_o.restored_flag    = restored_d;
  end

  // State registers advance once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= '0;
      tgt_q      <= '0;
      awake_q    <= 1'b0;
      dir_q      <= 1'b0;
      cd_q       <= '0;
      restored_q <= 1'b0;
    end else if (en_i) begin
      cur_q      <= cur_d;
      tgt_q      <= tgt_d;
      awake_q    <= awake_d;
      dir_q      <= dir_d;
      cd_q       <= cd_d;
      restored_q <= restored_d;
    end
  end

  // Commands never disturb the motion timing state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && func_i != FUNC_TICK) |=> ($stable(awake_q) && $stable(cd_q) && $stable(dir_q)))
    else $error("command item changed the motion timing state");

  // A step always moves the current position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && step) |=> (cur_q != $past(cur_q)))
    else $error("step issued without a position change");

  // The driver only goes to sleep on arrival.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(awake_q) |-> (cur_q == tgt_q))
    else $error("driver slept before reaching the target");

  // Once set, the restored flag stays set until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(restored_q))
    else $error("restored flag cleared");

  // Without a processed item the positions hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> ($stable(cur_q) && $stable(tgt_q)))
    else $error("positions changed without an item");

endmodule
